@@ src/peafsm_pkg.sv @@
// Package with shared types, codes and constants of the power entry interlock.
`timescale 1ns / 1ps
`default_nettype none
package peafsm_pkg;

	typedef enum logic [3:0] {
		ST_LOCK    = 4'd0,
		ST_WCHAL   = 4'd1,
		ST_ARMED   = 4'd2,
		ST_CLEAR   = 4'd3,
		ST_WREADY  = 4'd4,
		ST_READY   = 4'd5,
		ST_PEND    = 4'd6,
		ST_WACK    = 4'd7,
		ST_STARTED = 4'd8
	} state_t;

	typedef enum logic [2:0] {
		OP_SAMPLE  = 3'd0,
		OP_FRAME   = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_CONFIRM = 3'd3,
		OP_PING    = 3'd4,
		OP_STOP    = 3'd5,
		OP_LOCAL   = 3'd6,
		OP_LINKERR = 3'd7
	} op_t;

	localparam logic [3:0] K_PREPARE    = 4'd0;
	localparam logic [3:0] K_READY      = 4'd1;
	localparam logic [3:0] K_ACK        = 4'd2;
	localparam logic [3:0] K_PING       = 4'd3;
	localparam logic [3:0] K_PONG       = 4'd4;
	localparam logic [3:0] K_STOP       = 4'd5;
	localparam logic [3:0] K_ABORT      = 4'd6;
	localparam logic [3:0] K_REQUEST    = 4'd7;
	localparam logic [3:0] K_DISARM_ACK = 4'd8;
	localparam logic [3:0] K_START      = 4'd9;

	localparam logic [1:0] REG_PREPARE  = 2'd0;
	localparam logic [1:0] REG_START    = 2'd1;
	localparam logic [1:0] REG_WATCHDOG = 2'd2;

	localparam int IN_BITS  = 176;
	localparam int OUT_BITS = 112;

	// One input item.
	typedef struct packed {
		logic [31:0] value;
		logic [63:0] frame_session;
		logic [3:0]  frame_kind;
		logic        start_button;
		logic        permit_seen;
		logic        hot_session;
		logic        hot_perm;
		logic        local_permit;
		logic        chain_ok;
		logic        rail_ok;
		logic [63:0] now_ms;
		logic [2:0]  operation;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [3:0]  fsm_code;
		logic        accepted;
		logic [31:0] tx_value;
		logic [63:0] tx_session;
		logic [3:0]  tx_kind;
		logic        transmit;
		logic        wdi_pulse;
		logic        seen_clear;
		logic        permit_set;
		logic        chal_active;
		logic        stop_n;
	} result_t;

	// Window registers.
	typedef struct packed {
		logic [31:0] prepare_window;
		logic [31:0] start_window;
		logic [31:0] watchdog_window;
	} cfg_t;

	// Interlock state kept between items.
	typedef struct packed {
		state_t      fsm;
		logic [63:0] last_time;
		logic        time_fault;
		logic [63:0] cur_session;
		logic [63:0] prev_session;
		logic [31:0] cur_intent;
		logic [31:0] intent_counter;
		logic [31:0] pending_pong;
		logic [31:0] ping_counter;
		logic [31:0] peer_ping_last;
		logic        released_flag;
		logic        local_seen_flag;
		logic        hot_seen_flag;
		logic [31:0] epoch_lcl;
		logic [31:0] epoch_lnk;
		logic [31:0] local_fed_epoch;
		logic [31:0] link_fed_epoch;
		logic [63:0] feed_time;
		logic [63:0] due_time;
	} ctx_t;

endpackage
`default_nettype wire

@@ src/power_entry_authorization_fsm.sv @@
// Top level of the source-side power entry interlock.
//
//   Port group     Dir  Bits  Contents
//   s_axis_*       in   176   one event: operation, time, signals, frame fields
//   m_axis_*       out  112   one result: pulses, frame to send, state code
//   APB            in/out 32  three window registers at 0x0, 0x4, 0x8
//
// An event is taken into an input register, worked out in one pass of logic
// and written to the result register; one event per cycle while the result
// register is empty or drained. The result register and the input register
// are parted, so an event may be taken while a result still waits. Reset
// leaves the interlock in lockout with all counters and windows at zero.
`timescale 1ns / 1ps
`default_nettype none
module power_entry_authorization_fsm (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// operation[2:0], now_ms[66:3], rail_ok[67], chain_ok[68], local_permit[69],
	// hot_perm[70], hot_session[71], permit_seen[72], start_button[73],
	// frame_kind[77:74], frame_session[141:78], value[173:142], zero fill to 175
	input  wire logic [peafsm_pkg::IN_BITS-1:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// stop_n[0], chal_active[1], permit_set[2], seen_clear[3], wdi_pulse[4],
	// transmit[5], tx_kind[9:6], tx_session[73:10], tx_value[105:74],
	// accepted[106], fsm_code[110:107], zero fill to 111
	output logic [peafsm_pkg::OUT_BITS-1:0] m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	peafsm_pkg::cfg_t    cfg;
	peafsm_pkg::item_t   item_s1;
	logic                valid_s1;
	peafsm_pkg::ctx_t    ctx_q;
	peafsm_pkg::ctx_t    ctx_nxt;
	peafsm_pkg::result_t res_nxt;
	peafsm_pkg::result_t res_q;
	logic                out_valid_q;
	logic                adv;

	assign pready = 1'b1;

	peafsm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	peafsm_core u_core (.item(item_s1), .cfg(cfg), .cur(ctx_q), .nxt(ctx_nxt), .res(res_nxt));

	// Stage 1 moves into the result register when it is empty or being drained.
	assign adv = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) item_s1 <= peafsm_pkg::item_t'(s_axis_tdata[173:0]);
	end

	// Interlock state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) ctx_q <= ctx_nxt;
			if (adv) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_nxt;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, res_q};

	// A lockout state never shows stop_n high.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[110:107] != peafsm_pkg::ST_LOCK)))
		else $error("stop_n disagrees with state code");
	// A held result keeps its value while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// Nothing is sent without the transmit flag.
	a_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[105:6] == '0)
		else $error("frame fields set without transmit");

endmodule
`default_nettype wire

@@ src/peafsm_cfg.sv @@
// APB register file holding the three window registers.
`timescale 1ns / 1ps
`default_nettype none
module peafsm_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output peafsm_pkg::cfg_t         cfg
);

	logic [1:0] idx;
	logic       wr;
	peafsm_pkg::cfg_t cfg_q;

	assign idx = paddr[3:2];
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (idx)
				peafsm_pkg::REG_PREPARE:  cfg_q.prepare_window  <= pwdata;
				peafsm_pkg::REG_START:    cfg_q.start_window    <= pwdata;
				peafsm_pkg::REG_WATCHDOG: cfg_q.watchdog_window <= pwdata;
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (idx)
				peafsm_pkg::REG_PREPARE:  prdata = cfg_q.prepare_window;
				peafsm_pkg::REG_START:    prdata = cfg_q.start_window;
				peafsm_pkg::REG_WATCHDOG: prdata = cfg_q.watchdog_window;
				default:                  prdata = '0;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/peafsm_core.sv @@
// Next-state and result logic for one event of the interlock.
`timescale 1ns / 1ps
`default_nettype none
module peafsm_core (
	input  wire peafsm_pkg::item_t   item,
	input  wire peafsm_pkg::cfg_t    cfg,
	input  wire peafsm_pkg::ctx_t    cur,
	output peafsm_pkg::ctx_t         nxt,
	output peafsm_pkg::result_t      res
);

	localparam logic [31:0] TOP32 = '1;

	logic disarmed;
	logic win_zero;

	assign disarmed = item.rail_ok && item.chain_ok && !item.local_permit &&
		!item.hot_perm && !item.hot_session;
	assign win_zero = (cfg.prepare_window == '0) || (cfg.start_window == '0) ||
		(cfg.watchdog_window == '0);

	// Sequential semantics of one event, written as a straight-line block.
	always_comb begin
		peafsm_pkg::ctx_t c;
		peafsm_pkg::result_t r;
		logic lock;
		logic timed;
		logic bad;
		logic [63:0] now;
		logic [63:0] sess;
		logic [31:0] val;
		logic [3:0] kind;
		logic [64:0] due_sum;
		logic [63:0] old_sess;
		c = cur;
		r = '0;
		lock = 1'b0;
		now = item.now_ms;
		sess = item.frame_session;
		val = item.value;
		kind = item.frame_kind;
		due_sum = '0;
		old_sess = cur.cur_session;
		timed = 1'b0;
		bad = 1'b0;

		// Sampling part, shared by every operation but stop and local progress.
		if (item.operation != peafsm_pkg::OP_STOP && item.operation != peafsm_pkg::OP_LOCAL) begin
			if (now < c.last_time) begin
				c.time_fault = 1'b1;
				lock = 1'b1;
			end else begin
				c.last_time = now;
				if (c.time_fault || !item.rail_ok || !item.chain_ok || win_zero) begin
					lock = 1'b1;
				end else if (c.fsm == peafsm_pkg::ST_LOCK) begin
					if (disarmed) begin
						c.fsm = peafsm_pkg::ST_WCHAL;
						c.feed_time = now;
					end
				end else begin
					timed = c.fsm == peafsm_pkg::ST_ARMED || c.fsm == peafsm_pkg::ST_CLEAR ||
						c.fsm == peafsm_pkg::ST_WREADY || c.fsm == peafsm_pkg::ST_PEND ||
						c.fsm == peafsm_pkg::ST_WACK;
					bad = (c.fsm <= peafsm_pkg::ST_READY &&
							(item.local_permit || item.hot_perm)) ||
						(c.fsm < peafsm_pkg::ST_WREADY && item.hot_session) ||
						(c.fsm >= peafsm_pkg::ST_WACK && (!item.local_permit ||
							!item.hot_perm || !item.hot_session)) ||
						(c.fsm >= peafsm_pkg::ST_READY && item.permit_seen &&
							!item.hot_perm) ||
						(c.fsm == peafsm_pkg::ST_PEND &&
							((c.local_seen_flag && !item.local_permit) ||
							(c.hot_seen_flag && !item.hot_perm))) ||
						(c.fsm > peafsm_pkg::ST_WREADY && !item.hot_session) ||
						(timed && now >= c.due_time) ||
						(now - c.feed_time >= {32'd0, cfg.watchdog_window});
					if (bad) lock = 1'b1;
				end
				if (!lock) begin
					if (c.fsm == peafsm_pkg::ST_READY) begin
						if (!item.start_button) c.released_flag = 1'b1;
						if (item.start_button && c.released_flag) begin
							due_sum = {1'b0, now} + {33'd0, cfg.start_window};
							if (c.intent_counter == TOP32 || due_sum[64]) begin
								lock = 1'b1;
							end else begin
								c.due_time = due_sum[63:0];
								c.intent_counter = c.intent_counter + 32'd1;
								c.cur_intent = c.intent_counter;
								c.released_flag = 1'b0;
								c.local_seen_flag = 1'b0;
								c.hot_seen_flag = 1'b0;
								c.fsm = peafsm_pkg::ST_PEND;
								r.permit_set = 1'b1;
							end
						end
					end else if (c.fsm == peafsm_pkg::ST_PEND) begin
						if (item.local_permit) c.local_seen_flag = 1'b1;
						if (item.hot_perm) c.hot_seen_flag = 1'b1;
						if (item.local_permit && item.hot_perm && item.hot_session) begin
							c.fsm = peafsm_pkg::ST_WACK;
							r.transmit = 1'b1;
							r.tx_kind = peafsm_pkg::K_REQUEST;
							r.tx_session = c.cur_session;
							r.tx_value = c.cur_intent;
						end
					end
				end
				if (!lock && c.fsm != peafsm_pkg::ST_LOCK &&
						c.epoch_lcl != c.local_fed_epoch &&
						(c.fsm == peafsm_pkg::ST_WCHAL || c.epoch_lnk != c.link_fed_epoch)) begin
					c.local_fed_epoch = c.epoch_lcl;
					c.link_fed_epoch = c.epoch_lnk;
					c.feed_time = now;
					r.wdi_pulse = 1'b1;
				end
			end
		end

		// Operation-specific part.
		if (!lock) begin
			case (peafsm_pkg::op_t'(item.operation))
				peafsm_pkg::OP_SAMPLE: ;
				peafsm_pkg::OP_FRAME: begin
					if (kind == peafsm_pkg::K_STOP || kind == peafsm_pkg::K_ABORT) begin
						lock = 1'b1;
					end else if (c.fsm == peafsm_pkg::ST_LOCK) begin
						lock = 1'b0;
					end else if (kind == peafsm_pkg::K_PREPARE) begin
						due_sum = {1'b0, now} + {33'd0, cfg.prepare_window};
						if (c.fsm != peafsm_pkg::ST_WCHAL || sess <= c.prev_session ||
								val != '0 || !disarmed || due_sum[64]) begin
							lock = 1'b1;
						end else begin
							c.due_time = due_sum[63:0];
							c.cur_session = sess;
							c.prev_session = sess;
							c.fsm = peafsm_pkg::ST_ARMED;
						end
					end else if (sess != c.cur_session || c.cur_session == '0) begin
						lock = 1'b1;
					end else if (kind == peafsm_pkg::K_READY && c.fsm == peafsm_pkg::ST_WREADY &&
							val == '0 && item.hot_session && !item.local_permit &&
							!item.hot_perm) begin
						c.fsm = peafsm_pkg::ST_READY;
						c.released_flag = 1'b0;
						if (c.epoch_lnk == TOP32) lock = 1'b1;
						else c.epoch_lnk = c.epoch_lnk + 32'd1;
					end else if (kind == peafsm_pkg::K_ACK && c.fsm == peafsm_pkg::ST_WACK &&
							val == c.cur_intent && now < c.due_time && item.local_permit &&
							item.hot_perm && item.hot_session) begin
						c.fsm = peafsm_pkg::ST_STARTED;
						if (c.epoch_lnk == TOP32) begin
							lock = 1'b1;
						end else begin
							c.epoch_lnk = c.epoch_lnk + 32'd1;
							r.transmit = 1'b1;
							r.tx_kind = peafsm_pkg::K_START;
							r.tx_session = c.cur_session;
							r.tx_value = c.cur_intent;
						end
					end else if (kind == peafsm_pkg::K_PING && val > c.peer_ping_last &&
							c.fsm >= peafsm_pkg::ST_READY) begin
						c.peer_ping_last = val;
						if (c.epoch_lnk == TOP32) begin
							lock = 1'b1;
						end else begin
							c.epoch_lnk = c.epoch_lnk + 32'd1;
							r.transmit = 1'b1;
							r.tx_kind = peafsm_pkg::K_PONG;
							r.tx_session = c.cur_session;
							r.tx_value = val;
						end
					end else if (kind == peafsm_pkg::K_PONG && val != '0 &&
							val == c.pending_pong) begin
						c.pending_pong = '0;
						if (c.epoch_lnk == TOP32) lock = 1'b1;
						else c.epoch_lnk = c.epoch_lnk + 32'd1;
					end else begin
						lock = 1'b1;
					end
				end
				peafsm_pkg::OP_CLEAR: begin
					if (c.fsm != peafsm_pkg::ST_ARMED || !disarmed || now >= c.due_time) begin
						lock = 1'b1;
					end else begin
						c.fsm = peafsm_pkg::ST_CLEAR;
						r.seen_clear = 1'b1;
						r.accepted = 1'b1;
					end
				end
				peafsm_pkg::OP_CONFIRM: begin
					if (c.fsm != peafsm_pkg::ST_CLEAR || !disarmed || item.permit_seen ||
							now >= c.due_time) begin
						lock = 1'b1;
					end else begin
						c.fsm = peafsm_pkg::ST_WREADY;
						r.transmit = 1'b1;
						r.tx_kind = peafsm_pkg::K_DISARM_ACK;
						r.tx_session = c.cur_session;
						r.tx_value = '0;
						r.accepted = 1'b1;
					end
				end
				peafsm_pkg::OP_PING: begin
					if (c.fsm >= peafsm_pkg::ST_READY && c.pending_pong == '0 &&
							c.ping_counter != TOP32) begin
						c.ping_counter = c.ping_counter + 32'd1;
						c.pending_pong = c.ping_counter;
						r.transmit = 1'b1;
						r.tx_kind = peafsm_pkg::K_PING;
						r.tx_session = c.cur_session;
						r.tx_value = c.ping_counter;
						r.accepted = 1'b1;
					end
				end
				peafsm_pkg::OP_STOP: lock = 1'b1;
				peafsm_pkg::OP_LOCAL: begin
					if (c.fsm != peafsm_pkg::ST_LOCK && val > c.epoch_lcl)
						c.epoch_lcl = val;
				end
				default: lock = 1'b1;
			endcase
		end

		// Lockout clears the session and all pulses; a stop reports an open session.
		if (lock) begin
			c.fsm = peafsm_pkg::ST_LOCK;
			c.cur_session = '0;
			c.cur_intent = '0;
			c.pending_pong = '0;
			c.released_flag = 1'b0;
			c.local_seen_flag = 1'b0;
			c.hot_seen_flag = 1'b0;
			c.local_fed_epoch = c.epoch_lcl;
			c.link_fed_epoch = c.epoch_lnk;
			r = '0;
			if (item.operation == peafsm_pkg::OP_STOP && old_sess != '0) begin
				r.transmit = 1'b1;
				r.tx_kind = peafsm_pkg::K_STOP;
				r.tx_session = old_sess;
			end
		end
		r.stop_n = c.fsm != peafsm_pkg::ST_LOCK;
		r.chal_active = c.fsm == peafsm_pkg::ST_ARMED || c.fsm == peafsm_pkg::ST_CLEAR;
		r.fsm_code = c.fsm;
		nxt = c;
		res = r;
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_power_entry_authorization_fsm.sv @@
// Testbench for the power entry interlock: directed and random events checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_power_entry_authorization_fsm;

	// Physical signal patterns, bit order {button, seen, hot_session, hot_perm,
	// local_permit, chain_ok, rail_ok}.
	localparam logic [6:0] SIG_DISARMED = 7'b0000011;
	localparam logic [6:0] SIG_HOT      = 7'b0010011;
	localparam logic [6:0] SIG_LIVE     = 7'b0011111;
	localparam logic [6:0] SIG_BUTTON   = 7'b1000000;
	localparam logic [6:0] SIG_SEEN     = 7'b0100000;
	localparam logic [63:0] TIME_TOP    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] WORD_TOP    = 32'hFFFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [peafsm_pkg::IN_BITS-1:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [peafsm_pkg::OUT_BITS-1:0] m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	power_entry_authorization_fsm dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Predicted interlock state and window settings.
	peafsm_pkg::state_t il_st;
	logic [63:0] il_last, il_cur_sess, il_prev_sess, il_feed, il_due;
	bit          il_tfault, il_released, il_lseen, il_hseen;
	logic [31:0] il_intent, il_intent_cnt, il_pend_pong, il_ping_cnt, il_peer_ping;
	logic [31:0] il_local_ep, il_link_ep, il_local_fed, il_link_fed;
	logic [31:0] win_prepare, win_start, win_watchdog;
	peafsm_pkg::result_t rsp;

	peafsm_pkg::result_t expected_results[$];
	logic [63:0] now_t;
	int          errors, beats_sent;
	int          idle_pct, stall_pct, noise_pct;

	function automatic void il_base();
		rsp = '0;
		rsp.stop_n = il_st != peafsm_pkg::ST_LOCK;
		rsp.chal_active = il_st == peafsm_pkg::ST_ARMED || il_st == peafsm_pkg::ST_CLEAR;
	endfunction

	function automatic void il_lock();
		il_st = peafsm_pkg::ST_LOCK;
		il_cur_sess = '0;
		il_intent = '0;
		il_pend_pong = '0;
		il_released = 0;
		il_lseen = 0;
		il_hseen = 0;
		il_local_fed = il_local_ep;
		il_link_fed = il_link_ep;
		il_base();
	endfunction

	function automatic bit disarmed(peafsm_pkg::item_t it);
		return it.rail_ok && it.chain_ok && !it.local_permit && !it.hot_perm &&
			!it.hot_session;
	endfunction

	function automatic bit il_arm(logic [63:0] now, logic [31:0] w);
		if (w == 0 || TIME_TOP - now < {32'd0, w})
			return 0;
		il_due = now + {32'd0, w};
		return 1;
	endfunction

	function automatic void il_emit(logic [3:0] k, logic [63:0] s, logic [31:0] v);
		rsp.transmit = 1'b1;
		rsp.tx_kind = k;
		rsp.tx_session = s;
		rsp.tx_value = v;
	endfunction

	// The link epoch saturates; reaching the top locks out.
	function automatic bit il_link_bump();
		if (il_link_ep == WORD_TOP) begin
			il_lock();
			return 0;
		end
		il_link_ep++;
		return 1;
	endfunction

	function automatic void il_sample(peafsm_pkg::item_t it);
		logic [63:0] now;
		bit timed, bad;
		now = it.now_ms;
		il_base();
		if (now < il_last) begin
			il_tfault = 1;
			il_lock();
			return;
		end
		il_last = now;
		if (il_tfault || !it.rail_ok || !it.chain_ok || win_prepare == 0 ||
				win_start == 0 || win_watchdog == 0) begin
			il_lock();
			return;
		end
		if (il_st == peafsm_pkg::ST_LOCK) begin
			if (disarmed(it)) begin
				il_st = peafsm_pkg::ST_WCHAL;
				il_feed = now;
			end
		end else begin
			timed = il_st == peafsm_pkg::ST_ARMED || il_st == peafsm_pkg::ST_CLEAR ||
				il_st == peafsm_pkg::ST_WREADY || il_st == peafsm_pkg::ST_PEND ||
				il_st == peafsm_pkg::ST_WACK;
			bad = (il_st <= peafsm_pkg::ST_READY && (it.local_permit || it.hot_perm)) ||
				(il_st < peafsm_pkg::ST_WREADY && it.hot_session) ||
				(il_st >= peafsm_pkg::ST_WACK && (!it.local_permit || !it.hot_perm ||
					!it.hot_session)) ||
				(il_st >= peafsm_pkg::ST_READY && it.permit_seen && !it.hot_perm) ||
				(il_st == peafsm_pkg::ST_PEND && ((il_lseen && !it.local_permit) ||
					(il_hseen && !it.hot_perm))) ||
				(il_st > peafsm_pkg::ST_WREADY && !it.hot_session) ||
				(timed && now >= il_due) ||
				(now - il_feed >= {32'd0, win_watchdog});
			if (bad) begin
				il_lock();
				return;
			end
		end

		// Button press after a release opens a new intent.
		if (il_st == peafsm_pkg::ST_READY) begin
			if (!it.start_button)
				il_released = 1;
			if (it.start_button && il_released) begin
				if (il_intent_cnt == WORD_TOP || !il_arm(now, win_start)) begin
					il_lock();
					return;
				end
				il_intent_cnt++;
				il_intent = il_intent_cnt;
				il_released = 0;
				il_lseen = 0;
				il_hseen = 0;
				il_st = peafsm_pkg::ST_PEND;
				rsp.permit_set = 1'b1;
			end
		end else if (il_st == peafsm_pkg::ST_PEND) begin
			if (it.local_permit)
				il_lseen = 1;
			if (it.hot_perm)
				il_hseen = 1;
			if (it.local_permit && it.hot_perm && it.hot_session) begin
				il_st = peafsm_pkg::ST_WACK;
				il_emit(peafsm_pkg::K_REQUEST, il_cur_sess, il_intent);
			end
		end

		// The watchdog is fed when the local epoch has moved on and, outside ST_WCHAL, the link epoch too.
		if (il_st != peafsm_pkg::ST_LOCK && il_local_ep != il_local_fed &&
				(il_st == peafsm_pkg::ST_WCHAL || il_link_ep != il_link_fed)) begin
			il_local_fed = il_local_ep;
			il_link_fed = il_link_ep;
			il_feed = now;
			rsp.wdi_pulse = 1'b1;
		end
		rsp.stop_n = il_st != peafsm_pkg::ST_LOCK;
		rsp.chal_active = il_st == peafsm_pkg::ST_ARMED || il_st == peafsm_pkg::ST_CLEAR;
	endfunction

	function automatic void il_frame(peafsm_pkg::item_t it);
		logic [3:0] k;
		logic [63:0] s;
		logic [31:0] v;
		k = it.frame_kind;
		s = it.frame_session;
		v = it.value;
		il_sample(it);
		if (k == peafsm_pkg::K_STOP || k == peafsm_pkg::K_ABORT) begin
			il_lock();
			return;
		end
		if (il_st == peafsm_pkg::ST_LOCK)
			return;
		if (k == peafsm_pkg::K_PREPARE) begin
			if (il_st != peafsm_pkg::ST_WCHAL || s <= il_prev_sess || v != 0 ||
					!disarmed(it) || !il_arm(it.now_ms, win_prepare)) begin
				il_lock();
				return;
			end
			il_cur_sess = s;
			il_prev_sess = s;
			il_st = peafsm_pkg::ST_ARMED;
			rsp.chal_active = 1'b1;
			return;
		end
		if (s != il_cur_sess || il_cur_sess == 0) begin
			il_lock();
			return;
		end
		if (k == peafsm_pkg::K_READY) begin
			if (il_st == peafsm_pkg::ST_WREADY && v == 0 && it.hot_session &&
					!it.local_permit && !it.hot_perm) begin
				il_st = peafsm_pkg::ST_READY;
				il_released = 0;
				void'(il_link_bump());
				return;
			end
		end else if (k == peafsm_pkg::K_ACK) begin
			if (il_st == peafsm_pkg::ST_WACK && v == il_intent && it.now_ms < il_due &&
					it.local_permit && it.hot_perm && it.hot_session) begin
				il_st = peafsm_pkg::ST_STARTED;
				if (il_link_bump())
					il_emit(peafsm_pkg::K_START, il_cur_sess, il_intent);
				return;
			end
		end else if (k == peafsm_pkg::K_PING) begin
			if (v > il_peer_ping && il_st >= peafsm_pkg::ST_READY) begin
				il_peer_ping = v;
				if (il_link_bump())
					il_emit(peafsm_pkg::K_PONG, il_cur_sess, v);
				return;
			end
		end else if (k == peafsm_pkg::K_PONG) begin
			if (v != 0 && v == il_pend_pong) begin
				il_pend_pong = '0;
				void'(il_link_bump());
				return;
			end
		end
		il_lock();
	endfunction

	// Works out the result of one event and advances the predicted state.
	function automatic peafsm_pkg::result_t interlock_step(peafsm_pkg::item_t it);
		bit acc;
		logic [63:0] old;
		acc = 0;
		case (peafsm_pkg::op_t'(it.operation))
			peafsm_pkg::OP_SAMPLE: il_sample(it);
			peafsm_pkg::OP_FRAME: il_frame(it);
			peafsm_pkg::OP_CLEAR: begin
				il_sample(it);
				if (il_st != peafsm_pkg::ST_ARMED || !disarmed(it) || it.now_ms >= il_due) begin
					il_lock();
				end else begin
					il_st = peafsm_pkg::ST_CLEAR;
					rsp.chal_active = 1'b1;
					rsp.seen_clear = 1'b1;
					acc = 1;
				end
			end
			peafsm_pkg::OP_CONFIRM: begin
				il_sample(it);
				if (il_st != peafsm_pkg::ST_CLEAR || !disarmed(it) || it.permit_seen ||
						it.now_ms >= il_due) begin
					il_lock();
				end else begin
					il_st = peafsm_pkg::ST_WREADY;
					rsp.chal_active = 1'b0;
					il_emit(peafsm_pkg::K_DISARM_ACK, il_cur_sess, '0);
					acc = 1;
				end
			end
			peafsm_pkg::OP_PING: begin
				il_sample(it);
				if (il_st >= peafsm_pkg::ST_READY && il_pend_pong == 0 &&
						il_ping_cnt != WORD_TOP) begin
					il_ping_cnt++;
					il_pend_pong = il_ping_cnt;
					il_emit(peafsm_pkg::K_PING, il_cur_sess, il_pend_pong);
					acc = 1;
				end
			end
			peafsm_pkg::OP_STOP: begin
				old = il_cur_sess;
				il_lock();
				if (old != 0)
					il_emit(peafsm_pkg::K_STOP, old, '0);
			end
			peafsm_pkg::OP_LOCAL: begin
				if (il_st != peafsm_pkg::ST_LOCK && it.value > il_local_ep)
					il_local_ep = it.value;
				il_base();
			end
			default: begin
				il_sample(it);
				il_lock();
			end
		endcase
		rsp.accepted = acc;
		rsp.fsm_code = il_st;
		return rsp;
	endfunction

	function automatic peafsm_pkg::item_t mk(peafsm_pkg::op_t op, logic [6:0] sg,
			logic [3:0] k, logic [63:0] ss, logic [31:0] v);
		peafsm_pkg::item_t it;
		it.operation = op;
		it.now_ms = now_t;
		it.rail_ok = sg[0];
		it.chain_ok = sg[1];
		it.local_permit = sg[2];
		it.hot_perm = sg[3];
		it.hot_session = sg[4];
		it.permit_seen = sg[5];
		it.start_button = sg[6];
		it.frame_kind = k;
		it.frame_session = ss;
		it.value = v;
		return it;
	endfunction

	// Sends one event beat; each cycle before it is idle with the idle percentage.
	task automatic send(input peafsm_pkg::item_t it);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {2'd0, it};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(interlock_step(it));
		beats_sent++;
		@(negedge clk);
	endtask

	// A random event that does not move time backward.
	task automatic send_noise();
		logic [3:0] k;
		logic [63:0] ss;
		logic [31:0] v;
		k = $urandom_range(15);
		ss = (k == peafsm_pkg::K_PREPARE) ? il_prev_sess + $urandom_range(2) :
			{$urandom, $urandom};
		v = (k == peafsm_pkg::K_PING) ? il_peer_ping + $urandom_range(3) : $urandom;
		send(mk(peafsm_pkg::op_t'($urandom_range(7)), 7'($urandom), k, ss, v));
	endtask

	// Sometimes sends a random event, then advances time a little, sometimes a lot, and sends one event.
	task automatic go(peafsm_pkg::op_t op, logic [6:0] sg, logic [3:0] k = '0,
			logic [63:0] ss = '0, logic [31:0] v = '0);
		if (noise_pct > 0 && $urandom_range(99) < noise_pct)
			send_noise();
		now_t += ($urandom_range(11) == 0) ? $urandom_range(40) : $urandom_range(2);
		send(mk(op, sg, k, ss, v));
	endtask

	// Waits until every expected result has been checked.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_window(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			peafsm_pkg::REG_PREPARE: win_prepare = v;
			peafsm_pkg::REG_START: win_start = v;
			peafsm_pkg::REG_WATCHDOG: win_watchdog = v;
			default: ;
		endcase
	endtask

	task automatic set_windows(logic [31:0] p, logic [31:0] s, logic [31:0] w);
		drain();
		write_window(peafsm_pkg::REG_PREPARE, p);
		write_window(peafsm_pkg::REG_START, s);
		write_window(peafsm_pkg::REG_WATCHDOG, w);
	endtask

	// One well-formed session from lockout to start and a stop, with random traffic.
	task automatic run_session();
		logic [63:0] s;
		go(peafsm_pkg::OP_SAMPLE, SIG_DISARMED);
		go(peafsm_pkg::OP_LOCAL, SIG_DISARMED, '0, '0, il_local_ep + 1);
		s = il_prev_sess + 1 + $urandom_range(3);
		go(peafsm_pkg::OP_FRAME, SIG_DISARMED, peafsm_pkg::K_PREPARE, s, '0);
		go(peafsm_pkg::OP_CLEAR, SIG_DISARMED);
		go(peafsm_pkg::OP_CONFIRM, SIG_DISARMED);
		go(peafsm_pkg::OP_FRAME, SIG_HOT, peafsm_pkg::K_READY, s, '0);
		go(peafsm_pkg::OP_SAMPLE, SIG_HOT);
		go(peafsm_pkg::OP_SAMPLE, SIG_HOT | SIG_BUTTON);
		go(peafsm_pkg::OP_SAMPLE, SIG_LIVE);
		go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_ACK, s, il_intent);
		repeat ($urandom_range(8)) begin
			case ($urandom_range(5))
				0: go(peafsm_pkg::OP_SAMPLE, SIG_LIVE | 7'($urandom_range(1)) << 6);
				1: go(peafsm_pkg::OP_PING, SIG_LIVE);
				2: go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_PONG, s, il_pend_pong);
				3: go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_PING, s,
					il_peer_ping + 1 + $urandom_range(2));
				4: go(peafsm_pkg::OP_LOCAL, SIG_LIVE, '0, '0,
					il_local_ep + 1 + $urandom_range(3));
				default: go(peafsm_pkg::OP_SAMPLE, SIG_LIVE | SIG_SEEN);
			endcase
		end
		if ($urandom_range(1))
			go(peafsm_pkg::OP_STOP, SIG_LIVE);
		else
			go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_STOP, s, '0);
	endtask

	task automatic run_random(int beats, int idle, int stall);
		int first;
		bit paused;
		idle_pct = idle;
		stall_pct = stall;
		noise_pct = 10;
		first = beats_sent;
		paused = 0;
		while (beats_sent - first < beats) begin
			run_session();
			// Let the pipeline run dry once in the middle of the phase.
			if (!paused && beats_sent - first > beats / 2) begin
				drain();
				paused = 1;
			end
		end
		noise_pct = 0;
	endtask

	// Windows still zero after reset: every sample locks out, local progress is ignored.
	task automatic test_zero_windows();
		go(peafsm_pkg::OP_SAMPLE, SIG_DISARMED);
		go(peafsm_pkg::OP_LOCAL, SIG_DISARMED, '0, '0, 32'd5);
		go(peafsm_pkg::OP_STOP, SIG_DISARMED);
	endtask

	// Full handshake walk touching every operation but link error.
	task automatic test_session_walk();
		go(peafsm_pkg::OP_SAMPLE, SIG_DISARMED);
		go(peafsm_pkg::OP_FRAME, SIG_DISARMED, peafsm_pkg::K_PREPARE, 64'd1, '0);
		go(peafsm_pkg::OP_CLEAR, SIG_DISARMED);
		go(peafsm_pkg::OP_CONFIRM, SIG_DISARMED);
		go(peafsm_pkg::OP_FRAME, SIG_HOT, peafsm_pkg::K_READY, 64'd1, '0);
		go(peafsm_pkg::OP_SAMPLE, SIG_HOT);
		go(peafsm_pkg::OP_SAMPLE, SIG_HOT | SIG_BUTTON);
		go(peafsm_pkg::OP_SAMPLE, SIG_LIVE);
		go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_ACK, 64'd1, il_intent);
		go(peafsm_pkg::OP_PING, SIG_LIVE);
		go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_PONG, 64'd1, il_pend_pong);
		go(peafsm_pkg::OP_FRAME, SIG_LIVE, peafsm_pkg::K_PING, 64'd1, 32'd7);
		go(peafsm_pkg::OP_LOCAL, SIG_LIVE, '0, '0, 32'd3);
		go(peafsm_pkg::OP_STOP, SIG_LIVE);
	endtask

	// Link error, unknown kinds in and out of lockout, rail loss and abort.
	task automatic test_faults();
		go(peafsm_pkg::OP_LINKERR, SIG_DISARMED);
		go(peafsm_pkg::OP_SAMPLE, SIG_DISARMED);
		go(peafsm_pkg::OP_FRAME, SIG_DISARMED, 4'hC, 64'd9, '0);
		go(peafsm_pkg::OP_FRAME, SIG_DISARMED, 4'hF, 64'd9, '0);
		go(peafsm_pkg::OP_SAMPLE, SIG_DISARMED);
		go(peafsm_pkg::OP_SAMPLE, 7'b0000010);
		go(peafsm_pkg::OP_SAMPLE, SIG_DISARMED);
		go(peafsm_pkg::OP_FRAME, SIG_DISARMED, peafsm_pkg::K_ABORT, '0, '0);
	endtask

	// A zero in each window register forces lockout.
	task automatic test_window_zero();
		set_windows(32'd0, 32'd50, 32'd200);
		run_session();
		set_windows(32'd50, 32'd0, 32'd200);
		run_session();
		set_windows(32'd50, 32'd50, 32'd0);
		run_session();
	endtask

	// Time near the top, deadline overflow, largest fields and backward time last.
	task automatic test_extremes();
		set_windows(32'd100, 32'd100, WORD_TOP);
		now_t = TIME_TOP - 64'd20;
		send(mk(peafsm_pkg::OP_SAMPLE, 7'h7F, 4'hF, TIME_TOP, WORD_TOP));
		send(mk(peafsm_pkg::OP_SAMPLE, SIG_DISARMED, '0, '0, '0));
		send(mk(peafsm_pkg::OP_LOCAL, SIG_DISARMED, '0, '0, WORD_TOP));
		send(mk(peafsm_pkg::OP_FRAME, SIG_DISARMED, peafsm_pkg::K_PREPARE, TIME_TOP, '0));
		now_t = TIME_TOP;
		send(mk(peafsm_pkg::OP_SAMPLE, SIG_DISARMED, '0, '0, '0));
		now_t = '0;
		send(mk(peafsm_pkg::OP_SAMPLE, SIG_DISARMED, '0, '0, '0));
		now_t = TIME_TOP;
		send(mk(peafsm_pkg::OP_SAMPLE, SIG_DISARMED, '0, '0, '0));
		send(mk(peafsm_pkg::OP_STOP, SIG_DISARMED, '0, '0, '0));
	endtask

	// Result receiver stalls at random.
	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= stall_pct);

	task automatic cmp(string f, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t %s expected %0h got %0h", $time, f, e, a);
			errors++;
		end
	endtask

	// Check each result beat against the oldest expectation.
	always @(posedge clk) begin
		peafsm_pkg::result_t e, a;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			a = peafsm_pkg::result_t'(m_axis_tdata[110:0]);
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result %0h", $time, a);
				errors++;
			end else begin
				e = expected_results.pop_front();
				cmp("stop_n", e.stop_n, a.stop_n);
				cmp("chal_active", e.chal_active, a.chal_active);
				cmp("permit_set", e.permit_set, a.permit_set);
				cmp("seen_clear", e.seen_clear, a.seen_clear);
				cmp("wdi_pulse", e.wdi_pulse, a.wdi_pulse);
				cmp("transmit", e.transmit, a.transmit);
				cmp("tx_kind", e.tx_kind, a.tx_kind);
				cmp("tx_session", e.tx_session, a.tx_session);
				cmp("tx_value", e.tx_value, a.tx_value);
				cmp("accepted", e.accepted, a.accepted);
				cmp("fsm_code", e.fsm_code, a.fsm_code);
			end
		end
	end

	initial begin
		#2000000;
		$display("[power_entry_authorization_fsm] ERROR");
		$finish;
	end

	initial begin
		il_st = peafsm_pkg::ST_LOCK;
		{il_last, il_cur_sess, il_prev_sess, il_feed, il_due} = '0;
		{il_tfault, il_released, il_lseen, il_hseen} = '0;
		{il_intent, il_intent_cnt, il_pend_pong, il_ping_cnt, il_peer_ping} = '0;
		{il_local_ep, il_link_ep, il_local_fed, il_link_fed} = '0;
		{win_prepare, win_start, win_watchdog} = '0;
		now_t = '0;
		errors = 0;
		beats_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		noise_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_windows();
		set_windows(32'd1000, 32'd1000, 32'd5000);
		test_session_walk();
		test_faults();
		run_random(300, 0, 0);
		set_windows(32'd3, 32'd3, 32'd20);
		run_random(300, 70, 0);
		set_windows(WORD_TOP, WORD_TOP, WORD_TOP);
		run_random(300, 0, 70);
		set_windows(32'd1, 32'd30, 32'd60);
		run_random(300, 18, 18);
		test_window_zero();
		test_extremes();
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[power_entry_authorization_fsm] OK");
		else
			$display("[power_entry_authorization_fsm] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
